// ===== design/midi_held_note_tracker_with_panic_core_assert.svh =====
// Assertion macros used by the held-note tracker back end.
`ifndef MIDI_HELD_NOTE_TRACKER_WITH_PANIC_CORE_ASSERT_SVH
`define MIDI_HELD_NOTE_TRACKER_WITH_PANIC_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define MHNT_ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true outside reset.
`define MHNT_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MHNT_ASSERT_PROP(label, clk, rst, prop, msg)
`define MHNT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== design/mhnt_pkg.sv =====
package mhnt_pkg;

  localparam int HELD_LIMIT = 32;
  localparam int COUNT_W    = 6;
  localparam int NOTES      = 128;
  localparam int CHANNELS   = 16;
  localparam int NOTE_W     = 7;
  localparam int CH_W       = 4;
  localparam int POS_W      = NOTE_W + CH_W;

  localparam logic       OP_EVENT         = 1'b0;
  localparam logic       OP_FLUSH         = 1'b1;
  localparam logic [3:0] MSG_NOTE_OFF     = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON      = 4'h9;
  localparam logic [3:0] MSG_CTRL         = 4'hB;
  localparam logic [NOTE_W-1:0] CC_ALL_NOTES_OFF = 7'd123;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_SET,
    UPD_CLEAR
  } upd_kind_t;

  // One classified command, as handed from the front end to the back end.
  typedef struct packed {
    logic              do_flush;
    logic              zero_offset;
    logic              pass;
    upd_kind_t         upd;
    logic [CH_W-1:0]   ch;
    logic [NOTE_W-1:0] note;
    logic [7:0]        status;
    logic [7:0]        data_one;
    logic [7:0]        data_two;
    logic [15:0]       frame_offset;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [15:0] frame_offset;
    logic        generated;
    logic        untracked;
    logic        last;
  } result_t;

  // Command channel between front and back.
  typedef struct packed {
    logic empty;
    cmd_t head;
  } cmd_chan_t;

endpackage

// ===== design/mhnt_ram.sv =====
module mhnt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mhnt_front.sv =====
module mhnt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              opcode,
  input  logic [7:0]        status_byte,
  input  logic [7:0]        data_one,
  input  logic [7:0]        data_two,
  input  logic [15:0]       frame_offset,
  input  logic              cfg_write,
  input  logic              cfg_data,
  output mhnt_pkg::cmd_chan_t cmd_chan,
  input  logic              cmd_pop
);
  import mhnt_pkg::*;

  logic       power_on;
  cmd_t       cmd_q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       cmd_in;
  logic       do_push;
  logic       do_pop;
  logic [3:0] msg_type;

  assign full     = (cnt == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = cmd_pop && (cnt != 2'd0);
  assign msg_type = status_byte[7:4];

  // Classify the item: flush request, panic, and which map update it implies.
  always_comb begin
    cmd_in              = '0;
    cmd_in.ch           = status_byte[3:0];
    cmd_in.note         = data_one[NOTE_W-1:0];
    cmd_in.status       = status_byte;
    cmd_in.data_one     = data_one;
    cmd_in.data_two     = data_two;
    cmd_in.frame_offset = frame_offset;
    cmd_in.upd          = UPD_NONE;
    if (opcode == OP_FLUSH) begin
      cmd_in.do_flush    = 1'b1;
      cmd_in.zero_offset = 1'b1;
      cmd_in.pass        = 1'b0;
    end else begin
      cmd_in.pass     = 1'b1;
      cmd_in.do_flush = power_on && (msg_type == MSG_CTRL) &&
                        (data_one[NOTE_W-1:0] == CC_ALL_NOTES_OFF);
      if ((msg_type == MSG_NOTE_ON) && (data_two[6:0] != 7'd0)) begin
        cmd_in.upd = UPD_SET;
      end else if ((msg_type == MSG_NOTE_OFF) || (msg_type == MSG_NOTE_ON)) begin
        cmd_in.upd = UPD_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on <= 1'b1;
      wp       <= 1'b0;
      rp       <= 1'b0;
      cnt      <= 2'd0;
    end else begin
      if (cfg_write) begin
        power_on <= cfg_data;
      end
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q[wp] <= cmd_in;
    end
  end

  assign cmd_chan.empty = (cnt == 2'd0);
  assign cmd_chan.head  = cmd_q[rp];

endmodule

// ===== design/mhnt_back.sv =====
`include "midi_held_note_tracker_with_panic_core_assert.svh"

module mhnt_back (
  input  logic                clk,
  input  logic                rst,
  input  mhnt_pkg::cmd_chan_t cmd_chan,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output mhnt_pkg::result_t   result
);
  import mhnt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FL_CHK = 4'b0010,
    ST_UPD_RD = 4'b0100,
    ST_UPD_WR = 4'b1000
  } state_t;

  state_t              state, state_next;
  cmd_t                cur, cur_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [COUNT_W-1:0]  emitted, emitted_next;
  logic [COUNT_W-1:0]  held_count, held_count_next;
  logic [NOTES-1:0]    row_valid;
  logic                rvalid_q;

  logic                ram_we;
  logic [NOTE_W-1:0]   ram_waddr;
  logic [CHANNELS-1:0] ram_wdata;
  logic                ram_re;
  logic [NOTE_W-1:0]   ram_raddr;
  logic [CHANNELS-1:0] ram_rdata;

  logic [CHANNELS-1:0] row;
  logic [CHANNELS-1:0] mask;
  logic [COUNT_W-1:0]  emitted_inc;
  logic                flush_done;

  result_t             oq [2];
  logic                oq_wp;
  logic                oq_rp;
  logic [1:0]          oq_cnt;
  logic                oq_full;
  logic                out_push;
  result_t             out_item;
  logic                out_pop;

  mhnt_ram #(
    .WIDTH(CHANNELS),
    .DEPTH(NOTES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A row never written since the last clear reads as empty.
  assign row         = rvalid_q ? ram_rdata : '0;
  assign mask        = {{(CHANNELS-1){1'b0}}, 1'b1} << cur.ch;
  assign emitted_inc = emitted + COUNT_W'(1);
  assign oq_full     = (oq_cnt == 2'd2);
  assign out_pop     = pop && (oq_cnt != 2'd0);

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    pos_next        = pos;
    emitted_next    = emitted;
    held_count_next = held_count;
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cur.note;
    ram_wdata       = row;
    ram_re          = 1'b0;
    ram_raddr       = pos[NOTE_W-1:0];
    out_push        = 1'b0;
    out_item        = '0;
    flush_done      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!cmd_chan.empty) begin
          cmd_pop  = 1'b1;
          cur_next = cmd_chan.head;
          if (cmd_chan.head.do_flush && (held_count != '0)) begin
            pos_next     = '0;
            emitted_next = '0;
            ram_re       = 1'b1;
            ram_raddr    = '0;
            state_next   = ST_FL_CHK;
          end else if (cmd_chan.head.pass) begin
            ram_re     = 1'b1;
            ram_raddr  = cmd_chan.head.note;
            state_next = ST_UPD_WR;
          end
        end
      end
      ST_FL_CHK: begin
        // Data for position pos is on the read port; channel is the high part.
        if (row[pos[POS_W-1:NOTE_W]]) begin
          if (!oq_full) begin
            out_push              = 1'b1;
            out_item.status       = {MSG_NOTE_OFF, pos[POS_W-1:NOTE_W]};
            out_item.data_one     = {1'b0, pos[NOTE_W-1:0]};
            out_item.data_two     = 8'd0;
            out_item.frame_offset = cur.zero_offset ? 16'd0 : cur.frame_offset;
            out_item.generated    = 1'b1;
            out_item.untracked    = 1'b0;
            emitted_next          = emitted_inc;
            if (emitted_inc == held_count) begin
              out_item.last = !cur.pass;
              flush_done    = 1'b1;
              held_count_next = '0;
              state_next    = cur.pass ? ST_UPD_RD : ST_IDLE;
            end else begin
              pos_next  = pos + POS_W'(1);
              ram_re    = 1'b1;
              ram_raddr = pos_next[NOTE_W-1:0];
            end
          end
        end else begin
          pos_next  = pos + POS_W'(1);
          ram_re    = 1'b1;
          ram_raddr = pos_next[NOTE_W-1:0];
        end
      end
      ST_UPD_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = cur.note;
        state_next = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        if (!oq_full) begin
          out_push              = 1'b1;
          out_item.status       = cur.status;
          out_item.data_one     = cur.data_one;
          out_item.data_two     = cur.data_two;
          out_item.frame_offset = cur.frame_offset;
          out_item.generated    = 1'b0;
          out_item.last         = 1'b1;
          case (cur.upd)
            UPD_SET: begin
              if ((row & mask) == '0) begin
                if (held_count < COUNT_W'(HELD_LIMIT)) begin
                  ram_we          = 1'b1;
                  ram_wdata       = row | mask;
                  held_count_next = held_count + COUNT_W'(1);
                end else begin
                  out_item.untracked = 1'b1;
                end
              end
            end
            UPD_CLEAR: begin
              if ((row & mask) != '0) begin
                ram_we    = 1'b1;
                ram_wdata = row & ~mask;
                if (held_count != '0) begin
                  held_count_next = held_count - COUNT_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      row_valid  <= '0;
      rvalid_q   <= 1'b0;
      oq_wp      <= 1'b0;
      oq_rp      <= 1'b0;
      oq_cnt     <= 2'd0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      if (ram_re) begin
        rvalid_q <= row_valid[ram_raddr];
      end
      if (flush_done) begin
        row_valid <= '0;
      end else if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (out_push) begin
        oq_wp <= ~oq_wp;
      end
      if (out_pop) begin
        oq_rp <= ~oq_rp;
      end
      case ({out_push, out_pop})
        2'b10:   oq_cnt <= oq_cnt + 2'd1;
        2'b01:   oq_cnt <= oq_cnt - 2'd1;
        default: oq_cnt <= oq_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    pos     <= pos_next;
    emitted <= emitted_next;
    if (out_push) begin
      oq[oq_wp] <= out_item;
    end
  end

  assign empty  = (oq_cnt == 2'd0);
  assign result = oq[oq_rp];

  `MHNT_ASSERT_NEVER(a_count_cap, clk, rst, held_count > COUNT_W'(HELD_LIMIT), "held count above limit")
  `MHNT_ASSERT_PROP(a_push_room, clk, rst, out_push |-> !oq_full, "result pushed into full queue")
  `MHNT_ASSERT_PROP(a_flush_clear, clk, rst, flush_done |=> (held_count == '0) && (row_valid == '0), "flush left notes held")
  `MHNT_ASSERT_PROP(a_cmd_pop, clk, rst, cmd_pop |-> !cmd_chan.empty && (state == ST_IDLE), "command taken out of turn")

endmodule

// ===== design/midi_held_note_tracker_with_panic_core.sv =====
// Held-note tracker with all-notes-off panic. Every MIDI event pushed in comes
// back out unchanged as the last result of that item; note-on with nonzero
// velocity marks a note held (at most HELD_LIMIT notes at once, further new
// notes are flagged untracked), note-off or zero-velocity note-on releases it.
// A transport flush (opcode 1) or controller 123 while power_on is set first
// emits a velocity-0 note-off for every held note, channel-major then by note,
// and empties the map; a flush with nothing held produces no result. Both
// sides are queues: push/full in, empty/pop out, and power_on is written by
// cfg_write/cfg_data (reset value 1). An ordinary event passes through the
// command queue, the map read and update and the result queue; the back
// end takes no new event until the current one has queued its result. A
// panic scans the bitmap in channel-then-note order, one position per cycle
// but waiting at a held note while the result queue is full, stopping at
// the last held note; each position reads one 16-channel RAM row. Reset is
// immediate: per-row valid bits clear the map, with no clearing pass.
module midi_held_note_tracker_with_panic_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [7:0]  status_byte,
  input  logic [7:0]  data_one,
  input  logic [7:0]  data_two,
  input  logic [15:0] frame_offset,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_status,
  output logic [7:0]  out_data_one,
  output logic [7:0]  out_data_two,
  output logic [15:0] out_frame_offset,
  output logic        generated,
  output logic        untracked,
  output logic        last
);
  import mhnt_pkg::*;

  cmd_chan_t cmd_chan;
  logic      cmd_pop;
  result_t   result;

  // Front end: classify each transfer and hold it in the command queue.
  mhnt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .status_byte (status_byte),
    .data_one    (data_one),
    .data_two    (data_two),
    .frame_offset(frame_offset),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .cmd_chan    (cmd_chan),
    .cmd_pop     (cmd_pop)
  );

  // Back end: update the note map, walk it on a panic, queue the results.
  mhnt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd_chan(cmd_chan),
    .cmd_pop (cmd_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  assign out_status       = result.status;
  assign out_data_one     = result.data_one;
  assign out_data_two     = result.data_two;
  assign out_frame_offset = result.frame_offset;
  assign generated        = result.generated;
  assign untracked        = result.untracked;
  assign last             = result.last;

endmodule

// ===== tb/tb_midi_held_note_tracker_with_panic_core.sv =====
`timescale 1ns / 1ps

module tb_midi_held_note_tracker_with_panic_core;
  import mhnt_pkg::*;

  // Longest scan of the bitmap plus pipeline slack. Wait this long after the
  // last due result before touching power_on, since a flush with nothing
  // held produces no result to wait on.
  localparam int SETTLE_CYCLES  = 2300;
  // Cycles with no transfer on either side before the run is called hung.
  localparam int WATCHDOG_LIMIT = 20000;
  // Length of the receiver hold-off in the pressure phase.
  localparam int HOLD_CYCLES    = 1000;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [15:0] frame_offset;
  } midi_item_t;

  // One row of the directed table: the item, and where "typed" is set, the
  // single result that it must give.
  typedef struct packed {
    logic       typed;
    midi_item_t item;
    result_t    want;
  } dir_row_t;

  typedef enum {PH_FILL, PH_RELEASE, PH_PLAY, PH_PANIC, PH_NOISE} phrase_t;

  localparam result_t NO_WANT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        opcode = OP_EVENT;
  logic [7:0]  status_byte = 8'h00;
  logic [7:0]  data_one = 8'h00;
  logic [7:0]  data_two = 8'h00;
  logic [15:0] frame_offset = 16'h0000;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b1;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_status;
  logic [7:0]  out_data_one;
  logic [7:0]  out_data_two;
  logic [15:0] out_frame_offset;
  logic        generated;
  logic        untracked;
  logic        last;

  // Shadow of the held-note store: bit c of entry n set while note n on
  // channel c is held.
  logic [15:0] note_map [NOTES];
  logic [COUNT_W-1:0] held_total = '0;
  logic        power_on_shadow = 1'b1;

  // Results owed by the block, oldest first.
  result_t     due_results [$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int          feed_idle_pct = 0;
  int          drain_stall_pct = 0;
  bit          hold_request = 1'b0;

  phrase_t     phrase = PH_NOISE;
  int          phrase_left = 0;
  logic [3:0]  home_ch = '0;
  logic [6:0]  home_note = '0;

  midi_held_note_tracker_with_panic_core uut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .opcode           (opcode),
    .status_byte      (status_byte),
    .data_one         (data_one),
    .data_two         (data_two),
    .frame_offset     (frame_offset),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_data_one     (out_data_one),
    .out_data_two     (out_data_two),
    .out_frame_offset (out_frame_offset),
    .generated        (generated),
    .untracked        (untracked),
    .last             (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int n = 0; n < NOTES; n++) note_map[n] = '0;
  end

  // Append one result to the tail of the due list.
  function automatic void owe_result(input result_t r);
    due_results = {due_results, r};
  endfunction

  // Emit a velocity-0 note-off for every held note, channel-major, and
  // empty the shadow store.
  function automatic void release_all_notes(input logic [15:0] offset);
    result_t off;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int n = 0; n < NOTES; n++) begin
        if (note_map[n][ch]) begin
          off.status       = {MSG_NOTE_OFF, 4'(ch)};
          off.data_one     = 8'(n);
          off.data_two     = 8'h00;
          off.frame_offset = offset;
          off.generated    = 1'b1;
          off.untracked    = 1'b0;
          off.last         = 1'b0;
          owe_result(off);
          note_map[n][ch] = 1'b0;
        end
      end
    end
    held_total = '0;
  endfunction

  // Advance the shadow store by one accepted item and queue what it owes.
  function automatic void track_event(input midi_item_t it);
    logic [3:0] kind;
    logic [3:0] ch;
    logic [6:0] note;
    logic [6:0] vel;
    logic       untr;
    int         first;
    result_t    r;
    kind = it.status[7:4];
    ch   = it.status[3:0];
    note = it.data_one[6:0];
    vel  = it.data_two[6:0];
    untr = 1'b0;
    if (it.opcode == OP_FLUSH) begin
      // Transport flush: offsets go out as zero, last marks the final note-off.
      first = due_results.size();
      release_all_notes(16'h0000);
      if (due_results.size() > first) begin
        r = due_results.pop_back();
        r.last = 1'b1;
        owe_result(r);
      end
      return;
    end
    if (power_on_shadow && kind == MSG_CTRL && note == CC_ALL_NOTES_OFF)
      release_all_notes(it.frame_offset);
    if (kind == MSG_NOTE_ON && vel != 7'd0) begin
      if (!note_map[note][ch]) begin
        if (held_total < HELD_LIMIT) begin
          note_map[note][ch] = 1'b1;
          held_total = held_total + 1'b1;
        end else begin
          untr = 1'b1;
        end
      end
    end else if (kind == MSG_NOTE_OFF || kind == MSG_NOTE_ON) begin
      if (note_map[note][ch]) begin
        note_map[note][ch] = 1'b0;
        held_total = held_total - 1'b1;
      end
    end
    r.status       = it.status;
    r.data_one     = it.data_one;
    r.data_two     = it.data_two;
    r.frame_offset = it.frame_offset;
    r.generated    = 1'b0;
    r.untracked    = untr;
    r.last         = 1'b1;
    owe_result(r);
  endfunction

  // Pick one held note at random; return 0 when nothing is held.
  function automatic bit pick_held_note(output logic [3:0] ch, output logic [6:0] note);
    int rank;
    ch   = '0;
    note = '0;
    if (held_total == 0) return 1'b0;
    rank = $urandom_range(int'(held_total) - 1);
    for (int c = 0; c < CHANNELS; c++) begin
      for (int n = 0; n < NOTES; n++) begin
        if (note_map[n][c]) begin
          if (rank == 0) begin
            ch   = 4'(c);
            note = 7'(n);
            return 1'b1;
          end
          rank--;
        end
      end
    end
    return 1'b0;
  endfunction

  // Random items come in phrases: bursts of note-ons that run the store into
  // its cap, releases of held notes, playing around one key so that repeats
  // occur, panics, and short runs of raw noise.
  function automatic midi_item_t next_random_item();
    midi_item_t it;
    int         pick;
    logic [3:0] ch;
    logic [6:0] note;
    bit         hit;
    if (phrase_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        phrase = PH_FILL;
        phrase_left = $urandom_range(40, 8);
      end else if (pick < 50) begin
        phrase = PH_RELEASE;
        phrase_left = $urandom_range(16, 4);
      end else if (pick < 75) begin
        phrase = PH_PLAY;
        phrase_left = $urandom_range(20, 6);
      end else if (pick < 87) begin
        phrase = PH_PANIC;
        phrase_left = 1;
      end else begin
        phrase = PH_NOISE;
        phrase_left = $urandom_range(6, 1);
      end
      home_ch   = 4'($urandom);
      home_note = 7'($urandom);
    end
    phrase_left--;
    // Start from fully random bytes; bit 7 of the data bytes stays random
    // everywhere, since the block must ignore it yet pass it through.
    it.opcode       = OP_EVENT;
    it.status       = 8'($urandom);
    it.data_one     = 8'($urandom);
    it.data_two     = 8'($urandom);
    it.frame_offset = 16'($urandom);
    hit = pick_held_note(ch, note);
    case (phrase)
      PH_FILL: begin
        it.status = {MSG_NOTE_ON, it.status[3:0]};
        it.data_two[6:0] = 7'($urandom_range(127, 1));
      end
      PH_RELEASE: begin
        if (!hit) begin
          ch   = home_ch;
          note = home_note;
        end
        it.data_one[6:0] = note;
        if ($urandom_range(1)) begin
          it.status = {MSG_NOTE_OFF, ch};
        end else begin
          it.status = {MSG_NOTE_ON, ch};
          it.data_two[6:0] = 7'd0;
        end
      end
      PH_PLAY: begin
        pick = $urandom_range(99);
        if (pick < 50 || !hit) begin
          it.status = {MSG_NOTE_ON, home_ch};
          it.data_one[6:0] = home_note + 7'($urandom_range(3));
          it.data_two[6:0] = 7'($urandom_range(127, 1));
        end else if (pick < 80) begin
          it.status = {MSG_NOTE_OFF, ch};
          it.data_one[6:0] = note;
        end else begin
          // strike a held note again
          it.status = {MSG_NOTE_ON, ch};
          it.data_one[6:0] = note;
          it.data_two[6:0] = 7'($urandom_range(127, 1));
        end
      end
      PH_PANIC: begin
        if ($urandom_range(1)) begin
          it.opcode = OP_FLUSH;
        end else begin
          it.status = {MSG_CTRL, it.status[3:0]};
          it.data_one[6:0] = CC_ALL_NOTES_OFF;
        end
      end
      default: it.opcode = ($urandom_range(19) == 0) ? OP_FLUSH : OP_EVENT;
    endcase
    return it;
  endfunction

  // Directed table. Every row goes through the shadow store; typed rows also
  // carry their one result.
  function automatic dir_row_t directed_row(input int idx);
    dir_row_t row;
    row = '0;
    case (idx)
      // note-off for a note never held, all-zero fields
      0:  row = {1'b1, OP_EVENT, {MSG_NOTE_OFF, 4'h0}, 8'h00, 8'h00, 16'h0000,
                 {MSG_NOTE_OFF, 4'h0}, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1};
      // flush with nothing held: no result at all
      1:  row = {1'b0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 16'h0000, NO_WANT};
      // all-notes-off with nothing held: only the controller comes back
      2:  row = {1'b1, OP_EVENT, {MSG_CTRL, 4'h0}, 8'h7B, 8'h00, 16'hFFFF,
                 {MSG_CTRL, 4'h0}, 8'h7B, 8'h00, 16'hFFFF, 1'b0, 1'b0, 1'b1};
      // top channel, top note, top velocity
      3:  row = {1'b1, OP_EVENT, {MSG_NOTE_ON, 4'hF}, 8'h7F, 8'h7F, 16'hFFFF,
                 {MSG_NOTE_ON, 4'hF}, 8'h7F, 8'h7F, 16'hFFFF, 1'b0, 1'b0, 1'b1};
      4:  row = {1'b1, OP_EVENT, {MSG_NOTE_ON, 4'h0}, 8'h00, 8'h01, 16'h0001,
                 {MSG_NOTE_ON, 4'h0}, 8'h00, 8'h01, 16'h0001, 1'b0, 1'b0, 1'b1};
      // repeated note-on: stays held, not flagged
      5:  row = {1'b1, OP_EVENT, {MSG_NOTE_ON, 4'h0}, 8'h00, 8'h40, 16'h1234,
                 {MSG_NOTE_ON, 4'h0}, 8'h00, 8'h40, 16'h1234, 1'b0, 1'b0, 1'b1};
      // bit 7 set on note and velocity: tracked as note 127, bytes pass as is
      6:  row = {1'b1, OP_EVENT, {MSG_NOTE_ON, 4'h3}, 8'hFF, 8'hFF, 16'h8000,
                 {MSG_NOTE_ON, 4'h3}, 8'hFF, 8'hFF, 16'h8000, 1'b0, 1'b0, 1'b1};
      // velocity 0x80 counts as zero: a release of a note not held
      7:  row = {1'b1, OP_EVENT, {MSG_NOTE_ON, 4'h5}, 8'h3C, 8'h80, 16'h0000,
                 {MSG_NOTE_ON, 4'h5}, 8'h3C, 8'h80, 16'h0000, 1'b0, 1'b0, 1'b1};
      8:  row = {1'b0, OP_EVENT, {MSG_NOTE_ON, 4'h0}, 8'h40, 8'h64, 16'h00AA, NO_WANT};
      // note-off with bit 7 on the note byte releases note 64
      9:  row = {1'b1, OP_EVENT, {MSG_NOTE_OFF, 4'h0}, 8'hC0, 8'hFF, 16'h0055,
                 {MSG_NOTE_OFF, 4'h0}, 8'hC0, 8'hFF, 16'h0055, 1'b0, 1'b0, 1'b1};
      10: row = {1'b1, OP_EVENT, {MSG_NOTE_OFF, 4'h7}, 8'h10, 8'h00, 16'h7777,
                 {MSG_NOTE_OFF, 4'h7}, 8'h10, 8'h00, 16'h7777, 1'b0, 1'b0, 1'b1};
      // panic via controller number with bit 7 set, three notes held
      11: row = {1'b0, OP_EVENT, {MSG_CTRL, 4'h2}, 8'hFB, 8'h7F, 16'h4321, NO_WANT};
      12: row = {1'b1, OP_EVENT, {MSG_CTRL, 4'h2}, 8'h7B, 8'h00, 16'h0100,
                 {MSG_CTRL, 4'h2}, 8'h7B, 8'h00, 16'h0100, 1'b0, 1'b0, 1'b1};
      13: row = {1'b0, OP_EVENT, {MSG_NOTE_ON, 4'h9}, 8'h0A, 8'h05, 16'h0A0A, NO_WANT};
      14: row = {1'b0, OP_EVENT, {MSG_NOTE_ON, 4'h1}, 8'h14, 8'h7F, 16'h1414, NO_WANT};
      // zero-velocity note-on releases a held note
      15: row = {1'b1, OP_EVENT, {MSG_NOTE_ON, 4'h9}, 8'h0A, 8'h00, 16'h0B0B,
                 {MSG_NOTE_ON, 4'h9}, 8'h0A, 8'h00, 16'h0B0B, 1'b0, 1'b0, 1'b1};
      16: row = {1'b0, OP_EVENT, {MSG_NOTE_ON, 4'hC}, 8'h7F, 8'h33, 16'hC0C0, NO_WANT};
      // flush with notes held; the other fields of the item are ignored
      17: row = {1'b0, OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, NO_WANT};
      // other message types pass and change nothing
      18: row = {1'b1, OP_EVENT, 8'hA0, 8'h3C, 8'h40, 16'h0002,
                 8'hA0, 8'h3C, 8'h40, 16'h0002, 1'b0, 1'b0, 1'b1};
      19: row = {1'b1, OP_EVENT, 8'hCF, 8'h7F, 8'hFF, 16'h0003,
                 8'hCF, 8'h7F, 8'hFF, 16'h0003, 1'b0, 1'b0, 1'b1};
      20: row = {1'b1, OP_EVENT, {MSG_CTRL, 4'h0}, 8'h7A, 8'h00, 16'h0004,
                 {MSG_CTRL, 4'h0}, 8'h7A, 8'h00, 16'h0004, 1'b0, 1'b0, 1'b1};
      21: row = {1'b1, OP_EVENT, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b1};
      22: row = {1'b1, OP_EVENT, 8'h00, 8'h00, 8'h00, 16'h0000,
                 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1};
      23: row = {1'b0, OP_EVENT, {MSG_NOTE_ON, 4'h0}, 8'h7B, 8'h01, 16'h5555, NO_WANT};
      // panic from the top channel, one note held
      default: row = {1'b0, OP_EVENT, {MSG_CTRL, 4'hF}, 8'h7B, 8'h80, 16'hAAAA, NO_WANT};
    endcase
    return row;
  endfunction

  // Offer one item, idling first as the current phase asks; return at the
  // rising edge at which it transfers. Push stays high for the next call.
  task automatic offer_item(input midi_item_t it);
    @(negedge clk);
    while (feed_idle_pct != 0 && $urandom_range(99) < feed_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    opcode       <= it.opcode;
    status_byte  <= it.status;
    data_one     <= it.data_one;
    data_two     <= it.data_two;
    frame_offset <= it.frame_offset;
    do @(posedge clk); while (full);
  endtask

  // Drop push, drain every due result, then give a silent flush time to end.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_power(input logic value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    power_on_shadow = value;
  endtask

  task automatic run_phase(input logic power, input int idle_pct, input int stall_pct,
                           input bit pressure, input int items);
    midi_item_t it;
    settle();
    write_power(power);
    feed_idle_pct   = idle_pct;
    drain_stall_pct = stall_pct;
    // The receiver counts out its hold-off on its own; keep offering so the
    // block backs up and raises full.
    if (pressure) hold_request = 1'b1;
    for (int i = 0; i < items; i++) begin
      it = next_random_item();
      offer_item(it);
      track_event(it);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: pop at random per phase; on request, hold pop low for a long
  // stretch first.
  initial begin : drain
    forever begin
      @(negedge clk);
      if (hold_request) begin
        pop <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_request = 1'b0;
      end
      pop <= ($urandom_range(99) >= drain_stall_pct);
    end
  end

  // Check every result transfer against the oldest due result, and watch
  // for a hang.
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing due: status %h data %h %h",
                 out_status, out_data_one, out_data_two);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("out_status", want.status, out_status);
          check_field("out_data_one", want.data_one, out_data_one);
          check_field("out_data_two", want.data_two, out_data_two);
          check_field("out_frame_offset", want.frame_offset, out_frame_offset);
          check_field("generated", want.generated, generated);
          check_field("untracked", want.untracked, untracked);
          check_field("last", want.last, last);
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_midi_held_note_tracker_with_panic_core: done, errors");
        $finish;
      end
    end
  end

  initial begin : run
    dir_row_t row;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: power on, no idling on either side.
    write_power(1'b1);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_row(i);
      offer_item(row.item);
      track_event(row.item);
      // Typed rows give exactly one result; hold the block to the typed one.
      if (row.typed) begin
        void'(due_results.pop_back());
        owe_result(row.want);
      end
    end

    // Random part: phases vary idling on each side and power_on; the last adds the receiver hold-off.
    run_phase(1'b0, 0, 0, 1'b0, 80);
    run_phase(1'b1, 54, 0, 1'b0, 70);
    run_phase(1'b0, 0, 54, 1'b0, 60);
    run_phase(1'b1, 35, 35, 1'b0, 70);
    run_phase(1'b1, 0, 0, 1'b1, 50);

    settle();
    if (mismatches == 0) begin
      $display("tb_midi_held_note_tracker_with_panic_core: done, clean");
    end else begin
      $display("tb_midi_held_note_tracker_with_panic_core: done, errors");
    end
    $finish;
  end

endmodule
